/* src/pgsm_pkg.sv */
// Shared codes, widths and handshake structs for the position goal settle monitor.
package pgsm_pkg;

  // Operation codes carried by in_op.
  localparam logic [1:0] OP_VELOCITY = 2'd0;
  localparam logic [1:0] OP_START    = 2'd1;
  localparam logic [1:0] OP_CHECK    = 2'd2;
  localparam logic [1:0] OP_CANCEL   = 2'd3;

  // Result status codes carried by out_status.
  localparam logic [2:0] STS_VEL_SET   = 3'd0;
  localparam logic [2:0] STS_ACCEPTED  = 3'd1;
  localparam logic [2:0] STS_REJECTED  = 3'd2;
  localparam logic [2:0] STS_FEEDBACK  = 3'd3;
  localparam logic [2:0] STS_SUCCEEDED = 3'd4;
  localparam logic [2:0] STS_CANCELED  = 3'd5;
  localparam logic [2:0] STS_IGNORED   = 3'd6;

  // Percent divider sizing: 100 * moved needs 39 bits, the remainder is
  // compared against the divisor shifted up by PCT_QBITS - 1.
  localparam int PCT_QBITS = 11;
  localparam int NUM_W     = 32 + PCT_QBITS - 1;
  localparam logic [9:0] PCT_MAX = 10'd1023;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic exec;
    logic mul;
    logic div_step;
    logic load_out;
  } pgsm_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic need_div;
    logic div_last;
  } pgsm_sts_t;

endpackage

/* src/pgsm_ctrl.sv */
// Controller state machine: input and output handshakes and step sequencing.
module pgsm_ctrl import pgsm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  pgsm_sts_t sts,
  output pgsm_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  // The output register can take a new word when empty or being drained.
  assign out_free  = !out_valid_r || !out_stall;

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_div ? S_MUL : S_OUT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid flag follows loads and drains.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* src/pgsm_dp.sv */
// Datapath: goal state, step evaluation, serial percent divider and output word.
module pgsm_dp import pgsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  pgsm_cmd_t          cmd,
  output pgsm_sts_t          sts,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_velocity_command,
  input  logic signed [31:0] in_target_position,
  input  logic [30:0]        in_tolerance,
  input  logic [15:0]        in_timeout_ticks,
  input  logic signed [31:0] in_current_position,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_final_position,
  output logic [31:0]        out_position_error,
  output logic [15:0]        out_elapsed_ticks,
  output logic [9:0]         out_percent_complete,
  output logic               out_drive_mode,
  output logic signed [31:0] out_drive_target
);

  // Magnitude of a - b; always fits in 32 bits.
  function automatic logic [31:0] absdiff(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [32:0] m;
    begin
      d = {a[31], a} - {b[31], b};
      m = d[32] ? -d : d;
      return m[31:0];
    end
  endfunction

  // Configuration register.
  logic [7:0] stable_req_r;

  // Captured input word.
  logic [1:0]         op_r;
  logic signed [31:0] vel_r, tgt_r, cur_r;
  logic [30:0]        tol_r;
  logic [15:0]        tmo_r;

  // Goal state.
  logic               goal_active_r, goal_active_nxt;
  logic signed [31:0] held_vel_r, held_vel_nxt;
  logic signed [31:0] held_tgt_r, held_tgt_nxt;
  logic [30:0]        held_tol_r, held_tol_nxt;
  logic [15:0]        held_tmo_r, held_tmo_nxt;
  logic signed [31:0] start_pos_r, start_pos_nxt;
  logic [7:0]         stable_cnt_r, stable_cnt_nxt;
  logic [15:0]        tick_cnt_r, tick_cnt_nxt;

  // Staged result of the step.
  logic [2:0]         res_status_r, res_status_nxt;
  logic signed [31:0] res_fpos_r, res_fpos_nxt;
  logic [31:0]        res_err_r, res_err_nxt;
  logic [15:0]        res_elapsed_r, res_elapsed_nxt;

  // Divider operands and state.
  logic [31:0]      moved_r, dist_r;
  logic [NUM_W-1:0] rem_r, dsh_r;
  logic [PCT_QBITS-1:0] quo_r;
  logic [3:0]       cnt_r;
  logic             dist_zero_r, moved_zero_r;
  logic [38:0]      num_prod;
  logic             q_bit;
  logic [9:0]       pct;

  // Output register.
  logic [2:0]         out_status_r;
  logic signed [31:0] out_fpos_r, out_target_r;
  logic [31:0]        out_err_r;
  logic [15:0]        out_elapsed_r;
  logic [9:0]         out_pct_r;
  logic               out_mode_r;

  // Step evaluation terms.
  logic [31:0] err;
  logic [15:0] tick_inc;
  logic        timed_out;
  logic [7:0]  stable_inc;
  logic        need_div;
  logic        div_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stable_req_r <= 8'd1;
    end else if (cfg_wr_en) begin
      stable_req_r <= cfg_wr_data;
    end
  end

  // Capture the accepted input word.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_op;
      vel_r <= in_velocity_command;
      tgt_r <= in_target_position;
      tol_r <= in_tolerance;
      tmo_r <= in_timeout_ticks;
      cur_r <= in_current_position;
    end
  end

  // Check tick terms.
  always_comb begin
    err        = absdiff(cur_r, held_tgt_r);
    tick_inc   = (tick_cnt_r == 16'hFFFF) ? tick_cnt_r : tick_cnt_r + 16'd1;
    timed_out  = (held_tmo_r != 16'd0) && (tick_inc >= held_tmo_r);
    if (err <= {1'b0, held_tol_r}) begin
      stable_inc = (stable_cnt_r == 8'hFF) ? stable_cnt_r : stable_cnt_r + 8'd1;
    end else begin
      stable_inc = 8'd0;
    end
  end

  // Next goal state and staged result for one word.
  always_comb begin
    goal_active_nxt = goal_active_r;
    held_vel_nxt    = held_vel_r;
    held_tgt_nxt    = held_tgt_r;
    held_tol_nxt    = held_tol_r;
    held_tmo_nxt    = held_tmo_r;
    start_pos_nxt   = start_pos_r;
    stable_cnt_nxt  = stable_cnt_r;
    tick_cnt_nxt    = tick_cnt_r;
    res_status_nxt  = STS_IGNORED;
    res_fpos_nxt    = '0;
    res_err_nxt     = '0;
    res_elapsed_nxt = '0;
    need_div        = 1'b0;
    case (op_r)
      OP_VELOCITY: begin
        held_vel_nxt   = vel_r;
        res_status_nxt = STS_VEL_SET;
      end
      OP_START: begin
        if (goal_active_r) begin
          res_status_nxt = STS_REJECTED;
        end else begin
          held_tgt_nxt    = tgt_r;
          held_tol_nxt    = tol_r;
          held_tmo_nxt    = tmo_r;
          start_pos_nxt   = cur_r;
          stable_cnt_nxt  = '0;
          tick_cnt_nxt    = '0;
          goal_active_nxt = 1'b1;
          res_status_nxt  = STS_ACCEPTED;
        end
      end
      OP_CHECK: begin
        if (goal_active_r) begin
          res_fpos_nxt    = cur_r;
          res_err_nxt     = err;
          tick_cnt_nxt    = tick_inc;
          res_elapsed_nxt = tick_inc;
          if (timed_out) begin
            goal_active_nxt = 1'b0;
            res_status_nxt  = STS_CANCELED;
          end else begin
            stable_cnt_nxt = stable_inc;
            if (stable_inc >= stable_req_r) begin
              goal_active_nxt = 1'b0;
              res_status_nxt  = STS_SUCCEEDED;
            end else begin
              res_status_nxt = STS_FEEDBACK;
              need_div       = 1'b1;
            end
          end
        end
      end
      OP_CANCEL: begin
        if (goal_active_r) begin
          res_fpos_nxt    = cur_r;
          res_err_nxt     = err;
          res_elapsed_nxt = tick_cnt_r;
          goal_active_nxt = 1'b0;
          res_status_nxt  = STS_CANCELED;
        end
      end
      default: begin
        res_status_nxt = STS_IGNORED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_active_r <= 1'b0;
      held_vel_r    <= '0;
      held_tgt_r    <= '0;
      held_tol_r    <= '0;
      held_tmo_r    <= '0;
      start_pos_r   <= '0;
      stable_cnt_r  <= '0;
      tick_cnt_r    <= '0;
    end else if (cmd.exec) begin
      goal_active_r <= goal_active_nxt;
      held_vel_r    <= held_vel_nxt;
      held_tgt_r    <= held_tgt_nxt;
      held_tol_r    <= held_tol_nxt;
      held_tmo_r    <= held_tmo_nxt;
      start_pos_r   <= start_pos_nxt;
      stable_cnt_r  <= stable_cnt_nxt;
      tick_cnt_r    <= tick_cnt_nxt;
    end
  end

  // Staged result and divider operands, taken during evaluation.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status_r  <= res_status_nxt;
      res_fpos_r    <= res_fpos_nxt;
      res_err_r     <= res_err_nxt;
      res_elapsed_r <= res_elapsed_nxt;
      moved_r       <= absdiff(cur_r, start_pos_r);
      dist_r        <= absdiff(held_tgt_r, start_pos_r);
    end
  end

  // Serial restoring divider: 100 * moved / dist, one quotient bit a cycle.
  assign num_prod = {7'd0, moved_r} * 39'd100;
  assign q_bit    = (rem_r >= dsh_r);
  assign div_last = (cnt_r == 4'd0);

  // Status back to the controller.
  assign sts = {need_div, div_last};

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      rem_r        <= {{(NUM_W - 39){1'b0}}, num_prod};
      dsh_r        <= {dist_r, {(PCT_QBITS - 1){1'b0}}};
      quo_r        <= '0;
      cnt_r        <= 4'(PCT_QBITS - 1);
      dist_zero_r  <= (dist_r == 32'd0);
      moved_zero_r <= (moved_r == 32'd0);
    end else if (cmd.div_step) begin
      if (q_bit) begin
        rem_r <= rem_r - dsh_r;
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[PCT_QBITS-2:0], q_bit};
      cnt_r <= cnt_r - 4'd1;
    end
  end

  // Percent with saturation and the zero distance case.
  always_comb begin
    if (dist_zero_r) begin
      pct = moved_zero_r ? 10'd0 : PCT_MAX;
    end else if (quo_r[PCT_QBITS-1]) begin
      pct = PCT_MAX;
    end else begin
      pct = quo_r[9:0];
    end
  end

  // Output register; drive fields reflect the goal state after the step.
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r  <= res_status_r;
      out_fpos_r    <= res_fpos_r;
      out_err_r     <= res_err_r;
      out_elapsed_r <= res_elapsed_r;
      out_pct_r     <= (res_status_r == STS_FEEDBACK) ? pct : 10'd0;
      out_mode_r    <= goal_active_r;
      out_target_r  <= goal_active_r ? held_tgt_r : held_vel_r;
    end
  end

  assign out_status           = out_status_r;
  assign out_final_position   = out_fpos_r;
  assign out_position_error   = out_err_r;
  assign out_elapsed_ticks    = out_elapsed_r;
  assign out_percent_complete = out_pct_r;
  assign out_drive_mode       = out_mode_r;
  assign out_drive_target     = out_target_r;

endmodule

/* src/position_goal_settle_monitor.sv */
// Top level of the wheel drive mode and position goal settle monitor.
//
// Usage: one input word per operation (velocity command, start goal, check
// tick, cancel) on the in_ channel, each answered by exactly one result word
// on the out_ channel. A word is accepted when in_valid is high and in_stall
// is low; a result is taken when out_valid is high and out_stall is low.
// The settle check count is written through cfg_wr_en / cfg_wr_data while idle.
//
// A feedback check runs the percent divider, one quotient bit per cycle over
// 11 bits, before its result is registered; every other operation skips the
// divider. One word is in work at a time: a new word is taken only once the
// previous result has been loaded into the output register.
//
// Reset clears the goal state, the held targets and the output valid flag and
// sets the settle check count to 1. While out_stall holds a result, the next
// word may still be accepted and evaluated; it waits before the output
// register until the held result is taken.
module position_goal_settle_monitor import pgsm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_velocity_command,
  input  logic signed [31:0] in_target_position,
  input  logic [30:0]        in_tolerance,
  input  logic [15:0]        in_timeout_ticks,
  input  logic signed [31:0] in_current_position,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_final_position,
  output logic [31:0]        out_position_error,
  output logic [15:0]        out_elapsed_ticks,
  output logic [9:0]         out_percent_complete,
  output logic               out_drive_mode,
  output logic signed [31:0] out_drive_target
);

  pgsm_cmd_t cmd;
  pgsm_sts_t sts;

  pgsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pgsm_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_op                (in_op),
    .in_velocity_command  (in_velocity_command),
    .in_target_position   (in_target_position),
    .in_tolerance         (in_tolerance),
    .in_timeout_ticks     (in_timeout_ticks),
    .in_current_position  (in_current_position),
    .out_status           (out_status),
    .out_final_position   (out_final_position),
    .out_position_error   (out_position_error),
    .out_elapsed_ticks    (out_elapsed_ticks),
    .out_percent_complete (out_percent_complete),
    .out_drive_mode       (out_drive_mode),
    .out_drive_target     (out_drive_target)
  );

`ifndef NO_ASSERTIONS
  // An accepted word keeps the block busy on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while previous word still in work");

  // A finished goal always hands the drive back to velocity mode.
  a_end_velocity_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == STS_SUCCEEDED || out_status == STS_CANCELED))
      |-> !out_drive_mode)
    else $error("goal ended but drive still in position mode");

  // Percent complete is only reported with feedback.
  a_pct_feedback_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != STS_FEEDBACK) |-> (out_percent_complete == 10'd0))
    else $error("percent complete nonzero outside feedback");

  // Feedback is only given while a goal stays active.
  a_feedback_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STS_FEEDBACK) |-> out_drive_mode)
    else $error("feedback reported without an active goal");
`endif

endmodule

/* verif/position_goal_settle_monitor_tb.sv */
// Self-checking testbench for the position goal settle monitor: directed and random words.
module position_goal_settle_monitor_tb import pgsm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 3000;
  localparam int RANDOM_WORDS = 1400;
  localparam int SOAK_CHECKS = 120;
  localparam longint POS_MAX = 64'sh7FFF_FFFF;
  localparam longint POS_MIN = -64'sh8000_0000;

  // One command word and one result word, as the ports carry them.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] velocity;
    logic [31:0] target;
    logic [30:0] tolerance;
    logic [15:0] timeout;
    logic [31:0] position;
  } goal_cmd_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] end_pos;
    logic [31:0] pos_err;
    logic [15:0] elapsed;
    logic [9:0]  percent;
    logic        drive_mode;
    logic [31:0] drive_target;
  } goal_report_t;

  // A directed row: optional settle setting, the word, and a hand-typed result.
  typedef struct packed {
    logic         set_need;
    logic [7:0]   need;
    goal_cmd_t    cmd;
    logic         typed;
    goal_report_t report;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_op = OP_VELOCITY;
  logic [31:0] in_velocity_command = '0;
  logic [31:0] in_target_position = '0;
  logic [30:0] in_tolerance = '0;
  logic [15:0] in_timeout_ticks = '0;
  logic [31:0] in_current_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_status;
  logic [31:0] out_final_position;
  logic [31:0] out_position_error;
  logic [15:0] out_elapsed_ticks;
  logic [9:0]  out_percent_complete;
  logic        out_drive_mode;
  logic [31:0] out_drive_target;

  position_goal_settle_monitor u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_op                (in_op),
    .in_velocity_command  (in_velocity_command),
    .in_target_position   (in_target_position),
    .in_tolerance         (in_tolerance),
    .in_timeout_ticks     (in_timeout_ticks),
    .in_current_position  (in_current_position),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_final_position   (out_final_position),
    .out_position_error   (out_position_error),
    .out_elapsed_ticks    (out_elapsed_ticks),
    .out_percent_complete (out_percent_complete),
    .out_drive_mode       (out_drive_mode),
    .out_drive_target     (out_drive_target)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the goal state and the settle setting.
  logic        goal_on;
  logic [31:0] vel_q;
  logic [31:0] tgt_q;
  logic [30:0] tol_q;
  logic [15:0] tmo_q;
  logic [31:0] start_q;
  logic [7:0]  settle_cnt;
  logic [15:0] tick_q;
  logic [7:0]  settle_need;

  goal_report_t pending_reports[$];
  dir_row_t     dir_rows[$];
  logic         next_need_set = 1'b0;
  logic [7:0]   next_need = '0;

  int unsigned words_sent = 0;
  int unsigned useful_words = 0;
  int unsigned settings_used = 0;
  int unsigned mismatches = 0;
  int unsigned status_seen[8];
  int unsigned max_elapsed = 0;
  int unsigned quiet_cycles = 0;
  bit          steady = 1'b0;
  bit          hold_go = 1'b0;
  int unsigned hold_left = 0;

  // Absolute difference of two Q16.16 positions, exact in 32 bits.
  function automatic logic [31:0] span(logic [31:0] a, logic [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32]) d = -d;
    return d[31:0];
  endfunction

  function automatic logic [9:0] percent_of_travel(logic [31:0] cur);
    logic [63:0] moved;
    logic [63:0] travel;
    logic [63:0] p;
    moved = {32'd0, span(cur, start_q)};
    travel = {32'd0, span(tgt_q, start_q)};
    if (travel == 0) return (moved == 0) ? 10'd0 : PCT_MAX;
    p = (64'd100 * moved) / travel;
    return (p > 64'd1023) ? PCT_MAX : p[9:0];
  endfunction

  // Advance the shadow state by one word and return the result it must produce.
  function automatic goal_report_t predict_report(goal_cmd_t c);
    goal_report_t r;
    r = '0;
    r.status = STS_IGNORED;
    case (c.op)
      OP_VELOCITY: begin
        vel_q = c.velocity;
        r.status = STS_VEL_SET;
      end
      OP_START: begin
        if (goal_on) begin
          r.status = STS_REJECTED;
        end else begin
          tgt_q = c.target;
          tol_q = c.tolerance;
          tmo_q = c.timeout;
          start_q = c.position;
          settle_cnt = '0;
          tick_q = '0;
          goal_on = 1'b1;
          r.status = STS_ACCEPTED;
        end
      end
      default: begin
        if (goal_on) begin
          r.end_pos = c.position;
          r.pos_err = span(c.position, tgt_q);
          if (c.op == OP_CANCEL) begin
            goal_on = 1'b0;
            r.status = STS_CANCELED;
          end else begin
            if (tick_q != 16'hFFFF) tick_q = tick_q + 16'd1;
            if (tmo_q != 0 && tick_q >= tmo_q) begin
              goal_on = 1'b0;
              r.status = STS_CANCELED;
            end else begin
              if (r.pos_err <= {1'b0, tol_q}) begin
                if (settle_cnt != 8'hFF) settle_cnt = settle_cnt + 8'd1;
              end else begin
                settle_cnt = '0;
              end
              if (settle_cnt >= settle_need) begin
                goal_on = 1'b0;
                r.status = STS_SUCCEEDED;
              end else begin
                r.status = STS_FEEDBACK;
                r.percent = percent_of_travel(c.position);
              end
            end
          end
          r.elapsed = tick_q;
        end
      end
    endcase
    r.drive_mode = goal_on;
    r.drive_target = goal_on ? tgt_q : vel_q;
    return r;
  endfunction

  function automatic logic [31:0] clamp_pos(longint v);
    if (v > POS_MAX) return 32'h7FFF_FFFF;
    if (v < POS_MIN) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] pick_position();
    case ($urandom_range(2))
      0: return $urandom;
      1: return clamp_pos(longint'($urandom_range(2097152)) - 64'sd1048576);
      default: return clamp_pos(longint'($urandom_range(32'h1FFF_FFFF)) - 64'sh1000_0000);
    endcase
  endfunction

  function automatic goal_cmd_t random_cmd();
    goal_cmd_t c;
    c.op = 2'($urandom_range(3));
    c.velocity = $urandom;
    c.target = $urandom;
    c.tolerance = 31'($urandom);
    c.timeout = 16'($urandom);
    c.position = $urandom;
    return c;
  endfunction

  // Directed table builders.
  function automatic void dir_need(logic [7:0] v);
    next_need_set = 1'b1;
    next_need = v;
  endfunction

  function automatic void dir_cmd(logic [1:0] op, logic [31:0] vel, logic [31:0] tgt,
                                  logic [30:0] tol, logic [15:0] tmo, logic [31:0] pos);
    dir_row_t r;
    r = '0;
    r.set_need = next_need_set;
    r.need = next_need;
    r.cmd.op = op;
    r.cmd.velocity = vel;
    r.cmd.target = tgt;
    r.cmd.tolerance = tol;
    r.cmd.timeout = tmo;
    r.cmd.position = pos;
    next_need_set = 1'b0;
    dir_rows.push_back(r);
  endfunction

  function automatic void dir_typed(logic [2:0] st, logic [31:0] fpos, logic [31:0] err,
                                    logic [15:0] el, logic [9:0] pct, logic md,
                                    logic [31:0] tg);
    dir_row_t r;
    r = dir_rows.pop_back();
    r.typed = 1'b1;
    r.report.status = st;
    r.report.end_pos = fpos;
    r.report.pos_err = err;
    r.report.elapsed = el;
    r.report.percent = pct;
    r.report.drive_mode = md;
    r.report.drive_target = tg;
    dir_rows.push_back(r);
  endfunction

  // Offer one word, wait for it to be taken, then log what it must produce.
  task automatic send_cmd(goal_cmd_t c, logic typed, goal_report_t typed_rep);
    goal_report_t r;
    while (!steady && $urandom_range(99) < 19) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= c.op;
    in_velocity_command <= c.velocity;
    in_target_position <= c.target;
    in_tolerance <= c.tolerance;
    in_timeout_ticks <= c.timeout;
    in_current_position <= c.position;
    do @(posedge clk); while (in_stall);
    r = predict_report(c);
    pending_reports.push_back(typed ? typed_rep : r);
    words_sent++;
    if (r.status != STS_IGNORED) useful_words++;
  endtask

  // The setting is only changed once every result is back and nothing is offered.
  task automatic load_settle_need(logic [7:0] v);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settle_need = v;
    settings_used++;
  endtask

  // One goal from start to its end, with feedback positions that head for the target.
  task automatic run_goal_episode(bit long_settle);
    goal_cmd_t c;
    logic [31:0] tgt;
    logic [31:0] start;
    logic [30:0] tol;
    int unsigned n;
    int unsigned lim;
    int unsigned roll;
    longint off;
    if (goal_on) begin
      c = random_cmd();
      c.op = OP_CANCEL;
      send_cmd(c, 1'b0, '0);
    end
    c = random_cmd();
    if ($urandom_range(3) == 0) begin
      c.op = OP_VELOCITY;
      send_cmd(c, 1'b0, '0);
    end
    tgt = pick_position();
    start = pick_position();
    case ($urandom_range(3))
      0: tol = 31'($urandom);
      1: tol = 31'($urandom_range(4095));
      2: tol = '0;
      default: tol = 31'($urandom_range(32'h0010_0000));
    endcase
    c = random_cmd();
    c.op = OP_START;
    c.target = tgt;
    c.tolerance = tol;
    c.position = start;
    case ($urandom_range(2))
      0: c.timeout = '0;
      1: c.timeout = 16'($urandom_range(1, 30));
      default: c.timeout = 16'($urandom);
    endcase
    if (long_settle) c.timeout = '0;
    send_cmd(c, 1'b0, '0);
    n = long_settle ? 300 : $urandom_range(1, 40);
    lim = (tol > 4095) ? 4095 : tol;
    for (int k = 0; k < n && goal_on; k++) begin
      c = random_cmd();
      roll = $urandom_range(99);
      if (long_settle || roll >= 10) c.op = OP_CHECK;
      else if (roll < 4) c.op = OP_VELOCITY;
      else if (roll < 7) c.op = OP_START;
      else c.op = OP_CANCEL;
      case (long_settle ? 0 : $urandom_range(3))
        0: begin
          off = longint'($urandom_range(lim));
          if ($urandom_range(1)) off = -off;
          c.position = clamp_pos(longint'($signed(tgt)) + off);
        end
        1: begin
          off = longint'($signed(tgt)) - longint'($signed(start));
          c.position = clamp_pos(longint'($signed(start)) + off * $urandom_range(24) / 16);
        end
        2: c.position = $urandom;
        default: begin
          c.position = clamp_pos(longint'($signed(tgt)) + longint'(tol) + 1 +
                                 longint'($urandom_range(100)));
        end
      endcase
      send_cmd(c, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, a long hold-off on request, none in steady stretches.
  always @(posedge clk) begin
    if (hold_go) begin
      hold_go = 1'b0;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(99) < 19);
    end
  end

  // Compare every taken result with the oldest outstanding expectation.
  always @(posedge clk) begin : result_check
    goal_report_t want;
    goal_report_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.status = out_status;
      got.end_pos = out_final_position;
      got.pos_err = out_position_error;
      got.elapsed = out_elapsed_ticks;
      got.percent = out_percent_complete;
      got.drive_mode = out_drive_mode;
      got.drive_target = out_drive_target;
      status_seen[got.status]++;
      if (got.elapsed > max_elapsed) max_elapsed = got.elapsed;
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result word at %0t: status %0d", $realtime, got.status);
      end else begin
        want = pending_reports.pop_front();
        if (got.status !== want.status || got.end_pos !== want.end_pos ||
            got.pos_err !== want.pos_err || got.elapsed !== want.elapsed ||
            got.percent !== want.percent || got.drive_mode !== want.drive_mode ||
            got.drive_target !== want.drive_target) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at %0t: want st=%0d pos=%h err=%h ticks=%0d pct=%0d",
                     $realtime, want.status, want.end_pos, want.pos_err,
                     want.elapsed, want.percent);
            $display("                 want mode=%0d tgt=%h",
                     want.drive_mode, want.drive_target);
            $display("                 got  st=%0d pos=%h err=%h ticks=%0d pct=%0d",
                     got.status, got.end_pos, got.pos_err, got.elapsed, got.percent);
            $display("                 got  mode=%0d tgt=%h",
                     got.drive_mode, got.drive_target);
          end
        end
      end
    end
  end

  // Watchdog: too long without any word moving on either channel ends the run.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("No word moved for %0d cycles, %0d results outstanding", quiet_cycles,
                 pending_reports.size());
        $display("position_goal_settle_monitor regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    goal_cmd_t c;
    logic [7:0] phase_need[6];
    int unsigned phase_end;
    int unsigned base;

    goal_on = 1'b0;
    vel_q = '0;
    tgt_q = '0;
    tol_q = '0;
    tmo_q = '0;
    start_q = '0;
    settle_cnt = '0;
    tick_q = '0;
    settle_need = 8'd1;

    // Directed rows: no goal yet, extremes, a settle, a timeout of one tick.
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'h7FFF_FFFF);
    dir_typed(STS_IGNORED, 0, 0, 0, 0, 1'b0, 0);
    dir_cmd(OP_CANCEL, 0, 0, 0, 0, 32'h8000_0000);
    dir_typed(STS_IGNORED, 0, 0, 0, 0, 1'b0, 0);
    dir_cmd(OP_VELOCITY, 32'h7FFF_FFFF, 0, 0, 0, 0);
    dir_typed(STS_VEL_SET, 0, 0, 0, 0, 1'b0, 32'h7FFF_FFFF);
    dir_cmd(OP_VELOCITY, 32'h8000_0000, 0, 0, 0, 0);
    dir_typed(STS_VEL_SET, 0, 0, 0, 0, 1'b0, 32'h8000_0000);
    dir_cmd(OP_START, 0, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000);
    dir_typed(STS_ACCEPTED, 0, 0, 0, 0, 1'b1, 32'h7FFF_FFFF);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'h8000_0000);
    dir_typed(STS_FEEDBACK, 32'h8000_0000, 32'hFFFF_FFFF, 1, 0, 1'b1, 32'h7FFF_FFFF);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'h7FFF_FFFF);
    dir_typed(STS_SUCCEEDED, 32'h7FFF_FFFF, 0, 2, 0, 1'b0, 32'h8000_0000);
    dir_cmd(OP_VELOCITY, 32'h0001_0000, 0, 0, 0, 0);
    dir_typed(STS_VEL_SET, 0, 0, 0, 0, 1'b0, 32'h0001_0000);
    dir_cmd(OP_START, 0, 0, 31'h7FFF_FFFF, 16'd1, 0);
    dir_typed(STS_ACCEPTED, 0, 0, 0, 0, 1'b1, 0);
    // A velocity command during a goal is stored but the drive stays on position.
    dir_cmd(OP_VELOCITY, 32'h1234_5678, 0, 0, 0, 0);
    dir_typed(STS_VEL_SET, 0, 0, 0, 0, 1'b1, 0);
    dir_cmd(OP_START, 0, 32'd55, 0, 16'hFFFF, 32'd7);
    dir_typed(STS_REJECTED, 0, 0, 0, 0, 1'b1, 0);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'd5);
    dir_typed(STS_CANCELED, 32'd5, 32'd5, 1, 0, 1'b0, 32'h1234_5678);
    // Zero distance to target, moved away: percent saturates.
    dir_cmd(OP_START, 0, 0, 0, 0, 0);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'd100);
    dir_cmd(OP_CANCEL, 0, 0, 0, 0, -32'sd3);
    // Two checks to settle; zero distance and not moved reads zero percent.
    dir_need(8'd2);
    dir_cmd(OP_START, 0, 32'd100, 31'd10, 0, 32'd100);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'd100);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'd110);
    // Half way, a far move back saturates the percent, then timeout ends it at the target.
    dir_cmd(OP_START, 0, 32'd100, 0, 16'd3, 0);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'd50);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, -32'sd2000);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 32'd100);
    // A zero setting succeeds on the first check whatever the error.
    dir_need(8'd0);
    dir_cmd(OP_START, 0, 32'h7FFF_FFFF, 0, 16'hFFFF, 32'h8000_0000);
    dir_cmd(OP_CHECK, 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].set_need) load_settle_need(dir_rows[i].need);
      send_cmd(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].report);
    end

    // Soak: one goal that never settles, checked back to back with no idling.
    steady = 1'b1;
    load_settle_need(8'd1);
    c = random_cmd();
    c.op = OP_START;
    c.target = 32'h4000_0000;
    c.tolerance = '0;
    c.timeout = '0;
    c.position = '0;
    send_cmd(c, 1'b0, '0);
    repeat (SOAK_CHECKS) begin
      c = random_cmd();
      c.op = OP_CHECK;
      c.position = $urandom_range(32'h3FFF_FFFF);
      send_cmd(c, 1'b0, '0);
    end
    c.op = OP_CANCEL;
    send_cmd(c, 1'b0, '0);
    steady = 1'b0;

    // Random goals across several settle settings.
    phase_need[0] = 8'd3;
    phase_need[1] = 8'd0;
    phase_need[2] = 8'd255;
    phase_need[3] = 8'($urandom_range(4, 9));
    phase_need[4] = 8'd2;
    phase_need[5] = 8'd1;
    base = useful_words;
    for (int p = 0; p < 6; p++) begin
      load_settle_need(phase_need[p]);
      steady = (p == 3);
      phase_end = base + RANDOM_WORDS * (p + 1) / 6;
      if (phase_need[p] == 8'd255) run_goal_episode(1'b1);
      if (p == 4) hold_go = 1'b1;
      while (useful_words < phase_end) begin
        if ($urandom_range(99) < 85) begin
          run_goal_episode(1'b0);
        end else begin
          c = random_cmd();
          send_cmd(c, 1'b0, '0);
        end
      end
    end
    steady = 1'b0;

    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d words (%0d acted on) over %0d settle settings; tick count reached %0d.",
             words_sent, useful_words, settings_used, max_elapsed);
    $display("Results: %0d velocity, %0d accepted, %0d rejected, %0d feedback,",
             status_seen[STS_VEL_SET], status_seen[STS_ACCEPTED], status_seen[STS_REJECTED],
             status_seen[STS_FEEDBACK]);
    $display("  %0d settled, %0d canceled, %0d ignored; %0d mismatches.",
             status_seen[STS_SUCCEEDED], status_seen[STS_CANCELED],
             status_seen[STS_IGNORED], mismatches);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("position_goal_settle_monitor regression: pass");
    end else begin
      $display("position_goal_settle_monitor regression: fail");
    end
    $finish;
  end

endmodule

/* sim.f */
src/pgsm_pkg.sv
src/pgsm_ctrl.sv
src/pgsm_dp.sv
src/position_goal_settle_monitor.sv
verif/position_goal_settle_monitor_tb.sv
